// ===== rtl/wgm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wgm_pkg: shared types and constants of the weighted Gram matrix block.
// Holds the payload structs, the item kinds, the register indexes and the
// engine states.
// ----------------------------------------------------------------------------
package wgm_pkg;
  localparam int MAX_TEMPLATES = 8;
  localparam int MAX_SAMPLES   = 1024;
  localparam int TW = $clog2(MAX_TEMPLATES);
  localparam int SW = $clog2(MAX_SAMPLES);
  localparam int CFG_W = 11;
  localparam int ACC_W = 48;

  typedef enum logic [1:0] {
    KIND_LOAD_T = 2'd0, KIND_LOAD_W = 2'd1, KIND_COMPUTE = 2'd2, KIND_NONE = 2'd3
  } kind_t;

  localparam logic CFG_IDX_TEMPLATES = 1'b0;
  localparam logic CFG_IDX_SAMPLES   = 1'b1;

  typedef struct packed {
    logic [1:0]         kind;
    logic [2:0]         template_index;
    logic [9:0]         sample_index;
    logic signed [15:0] template_value;
    logic [15:0]        weight_value;
  } in_item_t;

  typedef struct packed {
    logic [2:0]         row;
    logic [2:0]         col;
    logic signed [47:0] covariance;
    logic               last;
  } out_item_t;

  typedef struct packed {
    kind_t              kind;
    logic [TW-1:0]      tidx;
    logic [SW-1:0]      sidx;
    logic [15:0]        data;
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_RUN, ST_DRAIN, ST_EMIT, ST_NEXT
  } eng_state_t;
endpackage

// ===== rtl/wgm_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wgm_front: input stage and command queue.
// Accepts items, drops unused kinds, and queues commands for the engine
// in a four-entry queue.
// ----------------------------------------------------------------------------
module wgm_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  wgm_pkg::in_item_t  in_data,
  output logic               cmd_valid,
  input  logic               cmd_pop,
  output wgm_pkg::cmd_t      cmd
);
  localparam int QD = 4;
  wgm_pkg::cmd_t    q_r [QD];
  logic [1:0]       wp_r, rp_r;
  logic [2:0]       cnt_r;
  logic             push;
  wgm_pkg::cmd_t    c;

  always_comb begin
    c.kind = wgm_pkg::kind_t'(in_data.kind);
    c.tidx = in_data.template_index;
    c.sidx = in_data.sample_index;
    c.data = (in_data.kind == wgm_pkg::KIND_LOAD_W) ? in_data.weight_value
                                                     : in_data.template_value;
  end

  assign in_stall  = (cnt_r == 3'(QD));
  assign push      = in_valid && !in_stall && (in_data.kind != wgm_pkg::KIND_NONE);
  assign cmd_valid = (cnt_r != 3'd0);
  assign cmd       = q_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) q_r[wp_r] <= c;
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 2'd1;
      if (cmd_pop) rp_r <= rp_r + 2'd1;
      cnt_r <= cnt_r + 3'(push) - 3'(cmd_pop);
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= 3'(QD))
    else $error("queue count overflow");
  assert property (@(posedge clk) disable iff (!rst_n) cmd_pop |-> cmd_valid)
    else $error("pop from empty queue");
  assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 3'd0 && !push) |=> cnt_r == 3'd0)
    else $error("queue count changed with no push");
endmodule

// ===== rtl/wgm_engine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wgm_engine: store writes and matrix accumulation.
// Performs loads, and for compute walks the upper triangle pairs, one sample a
// cycle through a registered multiply pipeline, then emits all entries.
// ----------------------------------------------------------------------------
module wgm_engine (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic                 cfg_index,
  input  logic [10:0]          cfg_wdata,
  input  logic                 cmd_valid,
  output logic                 cmd_pop,
  input  wgm_pkg::cmd_t        cmd,
  output logic                 out_valid,
  input  logic                 out_stall,
  output wgm_pkg::out_item_t   out_data
);
  localparam int TW = wgm_pkg::TW;
  localparam int SW = wgm_pkg::SW;
  localparam logic signed [48:0] AMAX = 49'sh0_7FFF_FFFF_FFFF;
  localparam logic signed [48:0] AMIN = -49'sh0_8000_0000_0000;

  logic [15:0] tmem [wgm_pkg::MAX_TEMPLATES*wgm_pkg::MAX_SAMPLES];
  logic [15:0] wmem [wgm_pkg::MAX_SAMPLES];
  logic signed [47:0] mat [wgm_pkg::MAX_TEMPLATES*wgm_pkg::MAX_TEMPLATES];

  logic [3:0]  nt_r;
  logic [10:0] ns_r;
  wgm_pkg::eng_state_t st_r, st_nxt;
  logic [TW-1:0] i_r, j_r;
  logic [10:0]   s_r;
  logic [2:0]    pend_r;
  logic          v1_r, v2_r, v3_r;
  logic signed [15:0] ti_r, tj_r;
  logic [15:0]   w_r;
  logic signed [31:0] pp_r;
  logic [15:0]   w2_r;
  logic signed [48:0] pr_r;
  logic signed [48:0] acc_r, sum;
  logic [TW-1:0] ei_r, ej_r;
  logic [TW-1:0] ei_nxt, ej_nxt;
  logic signed [47:0] cov_r;
  logic [3:0]    nt_eff;
  logic [10:0]   ns_eff;
  logic          rd, load_t, load_w;
  logic          emit_last;

  assign nt_eff = (nt_r > 4'(wgm_pkg::MAX_TEMPLATES)) ? 4'(wgm_pkg::MAX_TEMPLATES) : nt_r;
  assign ns_eff = (ns_r > 11'(wgm_pkg::MAX_SAMPLES)) ? 11'(wgm_pkg::MAX_SAMPLES) : ns_r;
  assign load_t = cmd_valid && st_r == wgm_pkg::ST_IDLE && cmd.kind == wgm_pkg::KIND_LOAD_T;
  assign load_w = cmd_valid && st_r == wgm_pkg::ST_IDLE && cmd.kind == wgm_pkg::KIND_LOAD_W;
  assign rd = (st_r == wgm_pkg::ST_RUN) && (s_r < ns_eff);
  assign emit_last = ({1'b0, ei_r} == nt_eff - 4'd1) && ({1'b0, ej_r} == nt_eff - 4'd1);

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      wgm_pkg::ST_IDLE:
        if (cmd_valid && cmd.kind == wgm_pkg::KIND_COMPUTE)
          st_nxt = (nt_eff == 4'd0) ? wgm_pkg::ST_IDLE : wgm_pkg::ST_RUN;
      wgm_pkg::ST_RUN:   if (!rd) st_nxt = wgm_pkg::ST_DRAIN;
      wgm_pkg::ST_DRAIN: if (pend_r == 3'd0) st_nxt = wgm_pkg::ST_NEXT;
      wgm_pkg::ST_NEXT:
        st_nxt = ({1'b0, i_r} == nt_eff - 4'd1) ? wgm_pkg::ST_EMIT : wgm_pkg::ST_RUN;
      wgm_pkg::ST_EMIT:  if (!out_stall && emit_last) st_nxt = wgm_pkg::ST_IDLE;
      default: st_nxt = wgm_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_pop = 1'b0;
    unique case (st_r)
      wgm_pkg::ST_IDLE: cmd_pop = cmd_valid;
      default: cmd_pop = 1'b0;
    endcase
  end

  always_comb begin
    ei_nxt = ei_r;
    ej_nxt = ej_r;
    if (st_r == wgm_pkg::ST_IDLE) begin
      ei_nxt = '0;
      ej_nxt = '0;
    end else if (st_r == wgm_pkg::ST_EMIT && !out_stall) begin
      if ({1'b0, ej_r} == nt_eff - 4'd1) begin
        ej_nxt = '0;
        ei_nxt = ei_r + 1'b1;
      end else ej_nxt = ej_r + 1'b1;
    end
  end

  assign out_valid = (st_r == wgm_pkg::ST_EMIT);
  always_comb begin
    out_data.row  = 3'(ei_r);
    out_data.col  = 3'(ej_r);
    out_data.covariance = cov_r;
    out_data.last = emit_last;
  end

  always_comb begin
    sum = acc_r + pr_r;
    if (sum > AMAX) sum = AMAX;
    else if (sum < AMIN) sum = AMIN;
  end

  always_ff @(posedge clk) begin
    if (load_t) tmem[{cmd.tidx, cmd.sidx}] <= cmd.data;
    if (load_w) wmem[cmd.sidx] <= cmd.data;
    ti_r <= tmem[{i_r, s_r[SW-1:0]}];
    tj_r <= tmem[{j_r, s_r[SW-1:0]}];
    w_r  <= wmem[s_r[SW-1:0]];
    pp_r <= ti_r * tj_r;
    w2_r <= w_r;
    pr_r <= (49'(pp_r) * 49'($signed({1'b0, w2_r}))) >>> 15;
    if (st_r == wgm_pkg::ST_DRAIN && pend_r == 3'd0) begin
      mat[{i_r, j_r}] <= acc_r[47:0];
      if (i_r != j_r) mat[{j_r, i_r}] <= acc_r[47:0];
    end
    cov_r <= mat[{ei_nxt, ej_nxt}];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= wgm_pkg::ST_IDLE;
      nt_r <= 4'(wgm_pkg::MAX_TEMPLATES); ns_r <= 11'(wgm_pkg::MAX_SAMPLES);
      v1_r <= 1'b0; v2_r <= 1'b0; v3_r <= 1'b0; pend_r <= '0;
      i_r <= '0; j_r <= '0; s_r <= '0; acc_r <= '0; ei_r <= '0; ej_r <= '0;
    end else begin
      st_r <= st_nxt;
      if (cfg_we && cfg_index == wgm_pkg::CFG_IDX_TEMPLATES) nt_r <= cfg_wdata[3:0];
      if (cfg_we && cfg_index == wgm_pkg::CFG_IDX_SAMPLES) ns_r <= cfg_wdata;
      v1_r <= rd; v2_r <= v1_r; v3_r <= v2_r;
      pend_r <= pend_r + 3'(rd) - 3'(v3_r);
      ei_r <= ei_nxt;
      ej_r <= ej_nxt;
      unique case (st_r)
        wgm_pkg::ST_IDLE: begin
          i_r <= '0; j_r <= '0; s_r <= '0; acc_r <= '0;
        end
        wgm_pkg::ST_RUN: begin
          if (rd) s_r <= s_r + 11'd1;
          if (v3_r) acc_r <= sum;
        end
        wgm_pkg::ST_DRAIN:
          if (v3_r) acc_r <= sum;
        wgm_pkg::ST_NEXT: begin
          s_r <= '0; acc_r <= '0;
          if ({1'b0, j_r} == nt_eff - 4'd1) begin
            i_r <= i_r + 1'b1; j_r <= i_r + 1'b1;
          end else j_r <= j_r + 1'b1;
        end
        default: ;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == wgm_pkg::ST_EMIT && out_stall) |=> st_r == wgm_pkg::ST_EMIT)
    else $error("stalled result dropped");
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd_pop |-> st_r == wgm_pkg::ST_IDLE)
    else $error("command taken while busy");
  assert property (@(posedge clk) disable iff (!rst_n)
    st_r == wgm_pkg::ST_NEXT |-> pend_r == 3'd0)
    else $error("entry closed with products in flight");
endmodule

// ===== rtl/weighted_gram_matrix_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// weighted_gram_matrix_top: weighted Gram matrix of stored templates.
// Items pass a four-entry queue; the engine then performs each load.
// A compute item holds the engine while it walks P = nt*(nt+1)/2 pairs,
// one sample a cycle through a three-stage multiply pipeline, and emits
// nt*nt results, one per cycle while out_stall is low. Reset sets
// templates_in_use 8 and samples_in_use 1024; stores hold undefined data.
// ----------------------------------------------------------------------------
module weighted_gram_matrix_top (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [10:0]         cfg_wdata,
  input  logic                in_valid,
  output logic                in_stall,
  input  wgm_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output wgm_pkg::out_item_t  out_data
);
  logic          cmd_valid, cmd_pop;
  wgm_pkg::cmd_t cmd;

  wgm_front u_front (.clk, .rst_n, .in_valid, .in_stall, .in_data,
                     .cmd_valid, .cmd_pop, .cmd);
  wgm_engine u_engine (.clk, .rst_n, .cfg_we, .cfg_index, .cfg_wdata,
                       .cmd_valid, .cmd_pop, .cmd, .out_valid, .out_stall, .out_data);
endmodule
